[src/bdq_pkg.sv]
// Shared constants and types for the bounded double-ended queue.
`default_nettype none

package bdq_pkg;

    // Default number of words held
    localparam int unsigned CAPACITY_DEF = 64;

    // Action codes
    localparam logic [1:0] ACT_PUSH_BACK  = 2'd0;
    localparam logic [1:0] ACT_PUSH_FRONT = 2'd1;
    localparam logic [1:0] ACT_POP_FRONT  = 2'd2;
    localparam logic [1:0] ACT_POP_BACK   = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // take the request and perform it
        logic emit;   // present the captured result
    } t_dp_cmd;

endpackage

`default_nettype wire

[src/bdq_ctrl.sv]
// Controller state machine: accepts a request, then presents its result.
`default_nettype none

module bdq_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    output logic                  o_busy,
    output logic                  o_done,
    output bdq_pkg::t_dp_cmd      o_cmd
);
    import bdq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RESP = 1'b1;

    logic r_state;
    logic n_state;

    // Next-state logic
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Drive handshake and datapath commands
    assign o_busy     = (r_state == S_RESP);
    assign o_done     = (r_state == S_RESP);
    assign o_cmd.load = (r_state == S_IDLE) && i_start;
    assign o_cmd.emit = (r_state == S_RESP);

endmodule

`default_nettype wire

[src/bdq_dpath.sv]
// Datapath: ring buffer memory, head and count registers, result registers.
`default_nettype none

module bdq_dpath #(
    parameter int unsigned CAPACITY = bdq_pkg::CAPACITY_DEF,
    parameter int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire bdq_pkg::t_dp_cmd    i_cmd,
    input  wire logic [1:0]          i_action,
    input  wire logic signed [31:0]  i_push_value,
    output logic signed [31:0]       o_popped_value,
    output logic [1:0]               o_status,
    output logic [CNT_W-1:0]         o_fill_count
);
    import bdq_pkg::*;

    localparam int unsigned SUM_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [SUM_W-1:0] CAP_SUM = SUM_W'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    logic signed [31:0] mem [CAPACITY];

    logic [IDX_W-1:0]   r_head;
    logic [CNT_W-1:0]   r_count;
    logic [1:0]         r_status;
    logic               r_pop_ok;
    logic signed [31:0] r_rd_data;

    logic [IDX_W-1:0]   n_head;
    logic [CNT_W-1:0]   n_count;
    logic [1:0]         n_status;
    logic               n_pop_ok;

    logic               is_push;
    logic               is_full;
    logic               is_empty;
    logic [SUM_W-1:0]   back_sum;
    logic [SUM_W-1:0]   last_sum;
    logic [IDX_W-1:0]   back_addr;
    logic [IDX_W-1:0]   last_addr;
    logic [IDX_W-1:0]   head_dec;
    logic [IDX_W-1:0]   head_inc;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;

    // Ring addresses; sums stay under twice the capacity if not empty
    always_comb begin
        back_sum  = SUM_W'(r_head) + SUM_W'(r_count);
        last_sum  = back_sum - SUM_W'(1);
        back_addr = (back_sum >= CAP_SUM) ? IDX_W'(back_sum - CAP_SUM) : IDX_W'(back_sum);
        last_addr = (last_sum >= CAP_SUM) ? IDX_W'(last_sum - CAP_SUM) : IDX_W'(last_sum);
        head_dec  = (r_head == '0) ? LAST_IDX : r_head - IDX_W'(1);
        head_inc  = (r_head == LAST_IDX) ? '0 : r_head + IDX_W'(1);
    end

    // Decide the effect of the requested action
    always_comb begin
        is_push  = (i_action == ACT_PUSH_BACK) || (i_action == ACT_PUSH_FRONT);
        is_full  = (r_count == CAP_CNT);
        is_empty = (r_count == '0);
        n_head   = r_head;
        n_count  = r_count;
        n_status = ST_OK;
        n_pop_ok = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = back_addr;
        rd_en    = 1'b0;
        rd_addr  = r_head;
        unique case (i_action)
            ACT_PUSH_BACK: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en   = i_cmd.load;
                    n_count = r_count + CNT_W'(1);
                end
            end
            ACT_PUSH_FRONT: begin
                wr_addr = head_dec;
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en   = i_cmd.load;
                    n_head  = head_dec;
                    n_count = r_count + CNT_W'(1);
                end
            end
            ACT_POP_FRONT: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    rd_en    = i_cmd.load;
                    n_pop_ok = 1'b1;
                    n_head   = head_inc;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            ACT_POP_BACK: begin
                rd_addr = last_addr;
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    rd_en    = i_cmd.load;
                    n_pop_ok = 1'b1;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
        if (is_push) begin
            n_pop_ok = 1'b0;
        end
    end

    // Ring memory: one write or one registered read per transfer
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_push_value;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Pointer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status <= n_status;
            r_pop_ok <= n_pop_ok;
        end
    end

    // Drop the read word unless a pop succeeded
    assign o_popped_value = (i_cmd.emit && r_pop_ok) ? r_rd_data : 32'sd0;
    assign o_status       = r_status;
    assign o_fill_count   = r_count;

endmodule

`default_nettype wire

[src/bounded_double_ended_queue_unit.sv]
// Top level of the bounded double-ended queue of signed 32-bit words.
`default_nettype none

// Usage:
//   Request channel: drive i_action and i_push_value with start high; the
//   transfer happens at a rising edge where start is high and busy is low.
//   Actions are push back, push front, pop front and pop back.
//   Result channel: o_done is high for exactly one cycle, the cycle after
//   the request transfer, with o_popped_value, o_status and o_fill_count.
//   The receiver cannot stall; the result is taken at the end of that cycle.
// Timing:
//   busy is high during the result cycle, so a new request cannot transfer
//   until the result of the last one has been presented. This order is set
//   by the registered read port of the ring memory and the two-state
//   controller that waits on it.
// Reset:
//   i_rst_n is synchronous, active low. It empties the queue (head and
//   count cleared) and returns the controller to idle; memory contents are
//   not cleared, as only written entries are ever read back.
//   A push on a full queue reports full, a pop on an empty queue reports
//   empty with a zero word; neither changes the queue.

module bounded_double_ended_queue_unit #(
    parameter int unsigned CAPACITY = bdq_pkg::CAPACITY_DEF,
    parameter int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          i_action,
    input  wire logic signed [31:0]  i_push_value,
    output logic                     o_done,
    output logic signed [31:0]       o_popped_value,
    output logic [1:0]               o_status,
    output logic [CNT_W-1:0]         o_fill_count
);
    import bdq_pkg::*;

    t_dp_cmd cmd;

    // Sequence each transfer
    bdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    // Hold the queue and form the result
    bdq_dpath #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_action       (i_action),
        .i_push_value   (i_push_value),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_fill_count   (o_fill_count)
    );

endmodule

`default_nettype wire

[src/bdq_checker.sv]
// Port-level checker for the double-ended queue and its bind.
`default_nettype none

module bdq_checker #(
    parameter int unsigned CAPACITY = bdq_pkg::CAPACITY_DEF,
    parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               o_done,
    input wire logic signed [31:0] o_popped_value,
    input wire logic [1:0]         o_status,
    input wire logic [CNT_W-1:0]   o_fill_count
);
    import bdq_pkg::*;

    // Every request transfer yields a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("no result after request transfer");

    // Results are single-cycle strobes
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // A refused action returns a zero word
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_OK)) |-> (o_popped_value == 32'sd0))
        else $error("nonzero word on refused action");

    // Full is reported only at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_FULL)) |-> (o_fill_count == CNT_W'(CAPACITY)))
        else $error("full status below capacity");

    // Empty is reported only with nothing held
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_EMPTY)) |-> (o_fill_count == '0))
        else $error("empty status with words held");

endmodule

bind bounded_double_ended_queue_unit bdq_checker #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
) u_bdq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_done         (o_done),
    .o_popped_value (o_popped_value),
    .o_status       (o_status),
    .o_fill_count   (o_fill_count)
);

`default_nettype wire
